@@ sv/ultrasonic_echo_ranger_core_assert.svh @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define UER_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("uer assertion failed");
`define UER_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("uer assertion failed");
`else
`define UER_ASSERT(label, prop)
`define UER_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ sv/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types and constants of the ranger pipeline.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned CNT_W  = 18;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned M_W    = 6;
  localparam int unsigned UM_W   = 20;

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [UM_W-1:0]  UM_PER_M = 20'd1000000;

  // floor(x / 1e6) == floor((x >> 6) / 15625); 1073 / 2^24 under-estimates by < 1
  localparam int unsigned      RECIP_SHIFT = 24;
  localparam logic [10:0]      RECIP_MUL   = 11'd1073;

  localparam logic [9:0]       RST_TRIG_TICKS    = 10'd11;
  localparam logic [15:0]      RST_INVALID_TICKS = 16'd25000;
  localparam logic [17:0]      RST_MAX_WAIT      = 18'd130000;
  localparam logic [9:0]       RST_SOUND_SPEED   = 10'd340;
  localparam logic [9:0]       RST_HOLDOFF       = 10'd145;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_WAIT = 3'd2,
    PH_ECHO = 3'd3,
    PH_HOLD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_NORESP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_TRIG_TICKS    = 3'd0,
    CFG_INVALID_TICKS = 3'd1,
    CFG_MAX_WAIT      = 3'd2,
    CFG_SOUND_SPEED   = 3'd3,
    CFG_HOLDOFF       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  trig_ticks;
    logic [15:0] invalid_ticks;
    logic [17:0] max_wait;
    logic [9:0]  holdoff;
  } uer_cfg_t;

  typedef struct packed {
    logic    trig;
    logic    busy;
    logic    done;
    status_e status;
    logic    load_val;
    logic    load_zero;
  } uer_info_t;

endpackage

@@ sv/uer_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Trigger / echo sequencer, one tick per accepted word, first pipeline stage.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic                           en_i,
  input  logic                           cmd_i,
  input  logic                           echo_i,
  input  uer_pkg::uer_cfg_t              cfg_i,
  output logic                           a_valid_o,
  output uer_pkg::uer_info_t             a_info_o,
  output logic [uer_pkg::DUR_W-1:0]      a_dur_o
);
  import uer_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] wait_q, wait_d;
  logic [CNT_W-1:0] echo_q, echo_d;
  logic             echo_prev_q;
  status_e          status_q, status_d;

  logic             a_valid_q;
  uer_info_t        a_info_q;
  logic [DUR_W-1:0] a_dur_q;

  logic             edge_seen;
  logic             echo_end;
  logic             dur_ok;
  logic             timeout;
  logic             trig_end;
  logic             hold_end;
  logic             short_trig;
  logic [CNT_W-1:0] wait_inc;
  logic [CNT_W-1:0] echo_inc;
  uer_info_t        info;

  assign wait_inc   = (wait_q == CNT_MAX) ? wait_q : wait_q + 18'd1;
  assign echo_inc   = (echo_q == CNT_MAX) ? echo_q : echo_q + 18'd1;
  assign edge_seen  = echo_i != echo_prev_q;
  assign echo_end   = edge_seen && (phase_q == PH_ECHO);
  assign dur_ok     = (echo_inc > {8'd0, cfg_i.trig_ticks}) &&
                      (echo_inc < {2'd0, cfg_i.invalid_ticks});
  assign timeout    = ((phase_q == PH_WAIT) || (phase_q == PH_ECHO)) && !echo_end &&
                      (wait_inc >= cfg_i.max_wait);
  assign trig_end   = wait_inc >= {8'd0, cfg_i.trig_ticks};
  assign hold_end   = wait_inc >= {8'd0, cfg_i.holdoff};
  assign short_trig = cfg_i.trig_ticks <= 10'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    echo_d  = echo_q;
    unique case (phase_q)
      PH_TRIG: begin
        wait_d = wait_inc;
        if (trig_end) begin
          phase_d = PH_WAIT;
          wait_d  = '0;
        end
      end
      PH_WAIT, PH_ECHO: begin
        wait_d = wait_inc;
        if (phase_q == PH_ECHO) begin
          echo_d = echo_inc;
        end
        if (edge_seen && (phase_q == PH_WAIT)) begin
          phase_d = PH_ECHO;
          echo_d  = '0;
        end else if (echo_end) begin
          if (dur_ok) begin
            phase_d = PH_IDLE;
          end else begin
            wait_d  = '0;
            phase_d = (cfg_i.holdoff == 10'd0) ? PH_IDLE : PH_HOLD;
          end
        end
        if (timeout) begin
          phase_d = PH_IDLE;
        end
      end
      PH_HOLD: begin
        wait_d = wait_inc;
        if (hold_end) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (cmd_i) begin
          if (short_trig) begin
            phase_d = PH_WAIT;
            wait_d  = '0;
          end else begin
            phase_d = PH_TRIG;
            wait_d  = 18'd1;
          end
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    info           = '0;
    info.status    = status_q;
    status_d       = status_q;
    unique case (phase_q)
      PH_TRIG: begin
        info.trig = 1'b1;
        info.busy = 1'b1;
      end
      PH_WAIT, PH_ECHO: begin
        info.busy = 1'b1;
        if (echo_end) begin
          info.done = 1'b1;
          if (dur_ok) begin
            info.load_val = 1'b1;
            status_d      = ST_VALID;
          end else begin
            info.load_zero = 1'b1;
            status_d       = ST_INVALID;
          end
        end else if (timeout) begin
          info.done = 1'b1;
          status_d  = ST_NORESP;
        end
      end
      PH_HOLD: begin
        info.busy = 1'b1;
      end
      default: begin
        info.trig = cmd_i;
        info.busy = cmd_i;
      end
    endcase
    info.status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      echo_q      <= '0;
      echo_prev_q <= 1'b0;
      status_q    <= ST_VALID;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      echo_q      <= echo_d;
      echo_prev_q <= echo_i;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_info_q <= info;
      a_dur_q  <= echo_inc[DUR_W-1:0];
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_info_o  = a_info_q;
  assign a_dur_o   = a_dur_q;

endmodule

@@ sv/uer_range.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger distance scaler
// Duration times speed over two, then a reciprocal estimate of whole metres.
// ----------------------------------------------------------------------------
module uer_range (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [9:0]                     speed_i,
  input  logic                           a_valid_i,
  input  uer_pkg::uer_info_t             a_info_i,
  input  logic [uer_pkg::DUR_W-1:0]      a_dur_i,
  output logic                           c_valid_o,
  output uer_pkg::uer_info_t             c_info_o,
  output logic [uer_pkg::DIST_W-1:0]     c_dist_o,
  output logic [uer_pkg::M_W-1:0]        c_qest_o
);
  import uer_pkg::*;

  logic              b_valid_q;
  uer_info_t         b_info_q;
  logic [DIST_W-1:0] b_dist_q;
  logic              c_valid_q;
  uer_info_t         c_info_q;
  logic [DIST_W-1:0] c_dist_q;
  logic [M_W-1:0]    c_qest_q;

  logic [DIST_W:0]   prod;
  logic [29:0]       qprod;

  assign prod  = {10'd0, a_dur_i} * {16'd0, speed_i};
  assign qprod = {11'd0, b_dist_q[DIST_W-1:6]} * {19'd0, RECIP_MUL};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_i;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_info_q <= a_info_i;
      b_dist_q <= prod[DIST_W:1];
      c_info_q <= b_info_q;
      c_dist_q <= b_dist_q;
      c_qest_q <= qprod[RECIP_SHIFT+M_W-1:RECIP_SHIFT];
    end
  end

  assign c_valid_o = c_valid_q;
  assign c_info_o  = c_info_q;
  assign c_dist_o  = c_dist_q;
  assign c_qest_o  = c_qest_q;

endmodule

@@ sv/uer_out.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger output stage
// Quotient correction, held distance and the output register.
// ----------------------------------------------------------------------------
module uer_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           c_valid_i,
  input  uer_pkg::uer_info_t             c_info_i,
  input  logic [uer_pkg::DIST_W-1:0]     c_dist_i,
  input  logic [uer_pkg::M_W-1:0]        c_qest_i,
  output logic                           out_valid_o,
  output uer_pkg::uer_info_t             out_info_o,
  output logic [uer_pkg::M_W-1:0]        held_m_o,
  output logic [uer_pkg::UM_W-1:0]       held_um_o
);
  import uer_pkg::*;

  logic              out_valid_q;
  uer_info_t         out_info_q;
  logic [M_W-1:0]    held_m_q;
  logic [UM_W-1:0]   held_um_q;

  logic [DIST_W:0]   qprod;
  logic [DIST_W-1:0] rem;
  logic              rem_hi;
  logic [M_W-1:0]    q_fix;
  logic [DIST_W-1:0] rem_fix;

  // estimate is q or q-1, so one compare and subtract settles it
  assign qprod   = {20'd0, c_qest_i} * {6'd0, UM_PER_M};
  assign rem     = c_dist_i - qprod[DIST_W-1:0];
  assign rem_hi  = rem >= {5'd0, UM_PER_M};
  assign q_fix   = rem_hi ? c_qest_i + 6'd1 : c_qest_i;
  assign rem_fix = rem_hi ? rem - {5'd0, UM_PER_M} : rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_m_q    <= '0;
      held_um_q   <= '0;
    end else if (en_i) begin
      out_valid_q <= c_valid_i;
      if (c_valid_i && c_info_i.load_val) begin
        held_m_q  <= q_fix;
        held_um_q <= rem_fix[UM_W-1:0];
      end else if (c_valid_i && c_info_i.load_zero) begin
        held_m_q  <= '0;
        held_um_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_info_q <= c_info_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_info_o  = out_info_q;
  assign held_m_o    = held_m_q;
  assign held_um_o   = held_um_q;

endmodule

@@ sv/ultrasonic_echo_ranger_core.sv @@
// Throughput: one word per cycle; stages are sequencer, multiply, reciprocal
// estimate, quotient correction, all advancing together while the output
// register is free or being taken.
// Reset: asynchronous, clears sequencer, counters, held distance and status,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Pulse-echo range finder controller, one echo sample per tick word.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_core_assert.svh"

module ultrasonic_echo_ranger_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] echo_level
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                      // [8:3] distance_m, [28:9] distance_um
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import uer_pkg::*;

  uer_cfg_t          cfg_q;
  logic [9:0]        speed_q;
  logic              en;
  logic              fire;

  logic              a_valid;
  uer_info_t         a_info;
  logic [DUR_W-1:0]  a_dur;
  logic              c_valid;
  uer_info_t         c_info;
  logic [DIST_W-1:0] c_dist;
  logic [M_W-1:0]    c_qest;
  logic              out_valid;
  uer_info_t         out_info;
  logic [M_W-1:0]    held_m;
  logic [UM_W-1:0]   held_um;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_ticks    <= RST_TRIG_TICKS;
      cfg_q.invalid_ticks <= RST_INVALID_TICKS;
      cfg_q.max_wait      <= RST_MAX_WAIT;
      cfg_q.holdoff       <= RST_HOLDOFF;
      speed_q             <= RST_SOUND_SPEED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIG_TICKS:    cfg_q.trig_ticks    <= cfg_data_i[9:0];
        CFG_INVALID_TICKS: cfg_q.invalid_ticks <= cfg_data_i[15:0];
        CFG_MAX_WAIT:      cfg_q.max_wait      <= cfg_data_i;
        CFG_SOUND_SPEED:   speed_q             <= cfg_data_i[9:0];
        CFG_HOLDOFF:       cfg_q.holdoff       <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign fire          = s_axis_tvalid && en;

  uer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .en_i      (en),
    .cmd_i     (s_axis_tuser),
    .echo_i    (s_axis_tdata[0]),
    .cfg_i     (cfg_q),
    .a_valid_o (a_valid),
    .a_info_o  (a_info),
    .a_dur_o   (a_dur)
  );

  uer_range u_range (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .speed_i   (speed_q),
    .a_valid_i (a_valid),
    .a_info_i  (a_info),
    .a_dur_i   (a_dur),
    .c_valid_o (c_valid),
    .c_info_o  (c_info),
    .c_dist_o  (c_dist),
    .c_qest_o  (c_qest)
  );

  uer_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .c_valid_i   (c_valid),
    .c_info_i    (c_info),
    .c_dist_i    (c_dist),
    .c_qest_i    (c_qest),
    .out_valid_o (out_valid),
    .out_info_o  (out_info),
    .held_m_o    (held_m),
    .held_um_o   (held_um)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, held_um, held_m, out_info.done, out_info.busy, out_info.trig};
  assign m_axis_tuser  = out_info.status;

  `UER_ASSERT(a_trig_busy, (m_axis_tvalid && out_info.trig) |-> out_info.busy)
  `UER_ASSERT(a_um_range, m_axis_tvalid |-> (held_um < UM_PER_M))
  `UER_ASSERT(a_held_change,
              ($past(rst_ni) && (!$stable(held_m) || !$stable(held_um))) |->
              (m_axis_tvalid && out_info.done &&
               (out_info.status == ST_VALID || out_info.status == ST_INVALID)))

endmodule
